/* src/dse_pkg.sv */
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and constants for the DMX512 slot engine.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MAX_SLOTS_DEF = 512;
  localparam int unsigned MIN_SLOTS_DEF = 24;

  localparam logic [1:0] MODE_OUT = 2'd1;
  localparam logic [1:0] MODE_IN  = 2'd2;

  localparam logic [0:0] CFG_MODE = 1'b0;
  localparam logic [0:0] CFG_MAX  = 1'b1;

  typedef enum logic [1:0] {
    PH_BREAK = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_IDLE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CMD_RX     = 2'd0,
    CMD_TX_RDY = 2'd1,
    CMD_WR     = 2'd2,
    CMD_RD     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BREAK = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  // per-transaction info carried alongside the slot memory read
  typedef struct packed {
    logic              tx_valid;
    kind_e             tx_kind;
    logic              tx_use_rd;
    logic              frame_done;
    logic [SLOT_W-1:0] frame_slots;
    logic              host_use_rd;
  } info_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    info_t             info;
  } req_t;

endpackage

/* src/dse_ram.sv */
// ----------------------------------------------------------------------------
// dse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 513,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dse_seq.sv */
// ----------------------------------------------------------------------------
// dse_seq
// Frame sequencer: mode and slot-count registers, frame phase and slot
// pointer, and decode of each transaction into a slot memory request.
// ----------------------------------------------------------------------------
module dse_seq #(
  parameter int unsigned MAX_SLOTS = dse_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MIN_SLOTS = dse_pkg::MIN_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [dse_pkg::SLOT_W-1:0] cfg_data_i,
  input  logic                       accept_i,
  input  logic [1:0]                 cmd_i,
  input  logic [dse_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       framing_error_i,
  input  logic [dse_pkg::SLOT_W-1:0] slot_index_i,
  input  logic [dse_pkg::BYTE_W-1:0] slot_value_i,
  output dse_pkg::req_t              req_o
);
  import dse_pkg::*;

  localparam logic [SLOT_W-1:0] MaxIdx = SLOT_W'(MAX_SLOTS);
  localparam logic [SLOT_W-1:0] MinIdx = SLOT_W'(MIN_SLOTS);

  phase_e            phase_q, phase_d;
  logic [SLOT_W-1:0] ptr_q, ptr_d;
  logic [1:0]        mode_q, mode_d;
  logic [SLOT_W-1:0] max_q, max_d;
  logic [SLOT_W-1:0] ptr_inc;
  logic              ptr_ok;
  cmd_e              cmd;

  assign cmd     = cmd_e'(cmd_i);
  assign ptr_inc = ptr_q + SLOT_W'(1);
  assign ptr_ok  = (ptr_q <= MaxIdx);

  // next state
  always_comb begin
    phase_d = phase_q;
    ptr_d   = ptr_q;
    mode_d  = mode_q;
    max_d   = max_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: begin
          mode_d = cfg_data_i[1:0];
          ptr_d  = '0;
          if (cfg_data_i[1:0] == MODE_OUT) begin
            phase_d = PH_START;
          end else if (cfg_data_i[1:0] == MODE_IN) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_BREAK;
          end
        end
        CFG_MAX: begin
          if (cfg_data_i < MinIdx) begin
            max_d = MinIdx;
          end else if (cfg_data_i > MaxIdx) begin
            max_d = MaxIdx;
          end else begin
            max_d = cfg_data_i;
          end
        end
        default: ;
      endcase
    end else if (accept_i) begin
      case (cmd)
        CMD_RX: begin
          if (mode_q == MODE_IN) begin
            if (framing_error_i) begin
              phase_d = PH_BREAK;
              ptr_d   = '0;
            end else if (phase_q == PH_BREAK) begin
              if (rx_byte_i == '0) begin
                ptr_d   = ptr_inc;
                phase_d = PH_DATA;
              end else begin
                phase_d = PH_IDLE;
              end
            end else if (phase_q == PH_DATA) begin
              ptr_d = ptr_inc;
              if (ptr_inc > MaxIdx) begin
                phase_d = PH_IDLE;
              end
            end
          end
        end
        CMD_TX_RDY: begin
          if (mode_q == MODE_OUT) begin
            case (phase_q)
              PH_DATA: begin
                ptr_d = ptr_inc;
                if (ptr_inc > max_q) begin
                  phase_d = PH_BREAK;
                end
              end
              PH_BREAK: begin
                ptr_d   = '0;
                phase_d = PH_START;
              end
              PH_START: begin
                ptr_d   = ptr_inc;
                phase_d = PH_DATA;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // memory request and result info
  always_comb begin
    req_o = '0;
    req_o.addr = ptr_q;
    case (cmd)
      CMD_RX: begin
        if (mode_q == MODE_IN) begin
          if (framing_error_i) begin
            req_o.info.frame_done  = (ptr_q != '0);
            req_o.info.frame_slots = ptr_q;
          end else if (phase_q == PH_BREAK) begin
            req_o.wr_en = ptr_ok && (rx_byte_i == '0);
            req_o.wdata = '0;
          end else if (phase_q == PH_DATA) begin
            req_o.wr_en = ptr_ok;
            req_o.wdata = rx_byte_i;
          end
        end
      end
      CMD_TX_RDY: begin
        if (mode_q == MODE_OUT) begin
          case (phase_q)
            PH_DATA: begin
              req_o.info.tx_valid  = 1'b1;
              req_o.info.tx_kind   = KIND_DATA;
              req_o.info.tx_use_rd = ptr_ok;
              req_o.rd_en          = ptr_ok;
            end
            PH_BREAK: begin
              req_o.info.tx_valid = 1'b1;
              req_o.info.tx_kind  = KIND_BREAK;
            end
            PH_START: begin
              req_o.info.tx_valid  = 1'b1;
              req_o.info.tx_kind   = KIND_START;
              req_o.info.tx_use_rd = ptr_ok;
              req_o.rd_en          = ptr_ok;
            end
            default: ;
          endcase
        end
      end
      CMD_WR: begin
        req_o.addr  = slot_index_i;
        req_o.wr_en = (slot_index_i <= MaxIdx);
        req_o.wdata = slot_value_i;
      end
      CMD_RD: begin
        req_o.addr             = slot_index_i;
        req_o.rd_en            = (slot_index_i <= MaxIdx);
        req_o.info.host_use_rd = (slot_index_i <= MaxIdx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BREAK;
      ptr_q   <= '0;
      mode_q  <= '0;
      max_q   <= MaxIdx;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      mode_q  <= mode_d;
      max_q   <= max_d;
    end
  end

endmodule

/* src/dmx512_slot_engine_unit.sv */
// ----------------------------------------------------------------------------
// dmx512_slot_engine_unit
// DMX512 frame engine around a slot memory (start code plus data slots).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transaction: tuser holds the command and the
//   framing error flag, tdata the received byte, slot index and slot value.
//   m_axis returns exactly one result per event: tuser holds the transmit
//   kind, tdata the remaining result fields.
//   cfg_we_i/cfg_idx_i/cfg_data_i write mode (index 0) and the last data
//   slot sent per frame (index 1); write only while no event is in flight.
//   Pipeline: an event taken is held in the read stage (slot memory read), then
//   in the result register, which offers it on m_axis.
//   Throughput: one event per cycle unless m_axis stalls; the sequencer and slot
//   memory each take a new transaction every cycle, the read is the first stage.
//   Reset: the slot memory is cleared one entry per cycle, all MAX_SLOTS+1
//   entries (513 by default); s_axis_tready stays low during that pass.
//   Stall: when m_axis_tready is low the result register and the read stage
//   hold, and s_axis_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module dmx512_slot_engine_unit #(
  parameter int unsigned MAX_SLOTS = dse_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MIN_SLOTS = dse_pkg::MIN_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [dse_pkg::SLOT_W-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // rx_byte, slot_index, slot_value
  input  logic [2:0]                 s_axis_tuser,  // cmd, framing_error
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tx_valid, tx_byte, frame_done, frame_slots, read_value
  output logic [31:0]                m_axis_tdata,
  output logic [1:0]                 m_axis_tuser   // tx_kind
);
  import dse_pkg::*;

  localparam int unsigned DEPTH = MAX_SLOTS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(MAX_SLOTS);

  req_t              req;
  logic              accept;
  logic              clearing_q;
  logic [SLOT_W-1:0] clr_q;
  logic              s1_valid_q;
  info_t             s1_info_q;
  logic              s1_adv;
  logic [BYTE_W-1:0] rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic              out_tx_valid_q;
  logic [BYTE_W-1:0] out_tx_byte_q, out_tx_byte_d;
  logic              out_done_q;
  logic [SLOT_W-1:0] out_slots_q;
  logic [BYTE_W-1:0] out_rd_q, out_rd_d;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  dse_seq #(
    .MAX_SLOTS(MAX_SLOTS),
    .MIN_SLOTS(MIN_SLOTS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .accept_i       (accept),
    .cmd_i          (s_axis_tuser[1:0]),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .framing_error_i(s_axis_tuser[2]),
    .slot_index_i   (s_axis_tdata[17:8]),
    .slot_value_i   (s_axis_tdata[25:18]),
    .req_o          (req)
  );

  // clearing pass owns the write port until done
  assign ram_we    = clearing_q || (accept && req.wr_en);
  assign ram_waddr = clearing_q ? clr_q[AW-1:0] : req.addr[AW-1:0];
  assign ram_wdata = clearing_q ? '0 : req.wdata;

  dse_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept && req.rd_en),
    .raddr_i(req.addr[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + SLOT_W'(1);
      if (clr_q == LastIdx) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= req.info;
    end
  end

  assign out_tx_byte_d = s1_info_q.tx_use_rd ? rdata : '0;
  assign out_rd_d      = s1_info_q.host_use_rd ? rdata : '0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_tx_valid_q <= s1_info_q.tx_valid;
      out_kind_q     <= s1_info_q.tx_kind;
      out_tx_byte_q  <= out_tx_byte_d;
      out_done_q     <= s1_info_q.frame_done;
      out_slots_q    <= s1_info_q.frame_slots;
      out_rd_q       <= out_rd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'b0, out_rd_q, out_slots_q, out_done_q, out_tx_byte_q,
                          out_tx_valid_q};

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready)
    else $error("event taken during slot memory clear");

  a_s1_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_info_q)))
    else $error("read stage lost a pending transaction");

  a_idle_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tx_valid_q) |-> (out_kind_q == KIND_BREAK && out_tx_byte_q == '0))
    else $error("transmit fields set without a character");

  a_done_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_done_q) |-> (out_slots_q == '0))
    else $error("frame slot count without frame end");

endmodule

/* dv/dmx512_slot_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// dmx512_slot_engine_unit_tb
// Self-checking bench for the DMX512 slot engine. A behavioral tracker of the
// slot memory and the frame sequencer predicts one result per event. Events
// are sent in random bursts against a receiver that stalls on its own.
// ----------------------------------------------------------------------------
module dmx512_slot_engine_unit_tb;
  import dse_pkg::*;

  localparam int unsigned ITEMS_TARGET = 1700;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned LAST_SLOT    = MAX_SLOTS_DEF;

  typedef struct packed {
    bit              tx_valid;
    bit [1:0]        tx_kind;
    bit [BYTE_W-1:0] tx_byte;
    bit              frame_done;
    bit [SLOT_W-1:0] frame_slots;
    bit [BYTE_W-1:0] read_value;
  } reply_t;

  class dmx_slot_tracker;
    bit [BYTE_W-1:0] slot_mem [LAST_SLOT+1];
    phase_e          cur_phase;
    bit [SLOT_W-1:0] slot_ptr;
    bit [1:0]        mode;
    bit [SLOT_W-1:0] last_tx_slot;
    reply_t          replies_due[$];
    int unsigned     fails;

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      cur_phase    = PH_BREAK;
      slot_ptr     = '0;
      mode         = '0;
      last_tx_slot = SLOT_W'(MAX_SLOTS_DEF);
      fails        = 0;
    endfunction

    function bit [BYTE_W-1:0] slot_rd(bit [SLOT_W-1:0] idx);
      return (idx > LAST_SLOT) ? '0 : slot_mem[idx];
    endfunction

    function void slot_wr(bit [SLOT_W-1:0] idx, bit [BYTE_W-1:0] val);
      if (idx <= LAST_SLOT) slot_mem[idx] = val;
    endfunction

    function void write_reg(logic [0:0] idx, logic [SLOT_W-1:0] data);
      if (idx == CFG_MODE) begin
        mode     = data[1:0];
        slot_ptr = '0;
        if (mode == MODE_OUT) cur_phase = PH_START;
        else if (mode == MODE_IN) cur_phase = PH_IDLE;
        else cur_phase = PH_BREAK;
      end else begin
        if (data < MIN_SLOTS_DEF) last_tx_slot = SLOT_W'(MIN_SLOTS_DEF);
        else if (data > MAX_SLOTS_DEF) last_tx_slot = SLOT_W'(MAX_SLOTS_DEF);
        else last_tx_slot = data;
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // advance the sequencer by one accepted event and queue its result
    function void play_event(cmd_e cmd, bit [7:0] rx, bit ferr, bit [SLOT_W-1:0] idx,
                             bit [7:0] val);
      reply_t r;
      r = '0;
      case (cmd)
        CMD_RX: begin
          if (mode == MODE_IN) begin
            if (ferr) begin
              cur_phase = PH_BREAK;
              if (slot_ptr != 0) begin
                r.frame_done  = 1'b1;
                r.frame_slots = slot_ptr;
              end
              slot_ptr = '0;
            end else if (cur_phase == PH_BREAK) begin
              if (rx == 8'h00) begin
                slot_wr(slot_ptr, 8'h00);
                slot_ptr  = slot_ptr + 1'b1;
                cur_phase = PH_DATA;
              end else begin
                cur_phase = PH_IDLE;
              end
            end else if (cur_phase == PH_DATA) begin
              slot_wr(slot_ptr, rx);
              slot_ptr = slot_ptr + 1'b1;
              if (slot_ptr > LAST_SLOT) cur_phase = PH_IDLE;
            end
          end
        end
        CMD_TX_RDY: begin
          if (mode == MODE_OUT) begin
            case (cur_phase)
              PH_DATA: begin
                r.tx_valid = 1'b1;
                r.tx_kind  = KIND_DATA;
                r.tx_byte  = slot_rd(slot_ptr);
                slot_ptr   = slot_ptr + 1'b1;
                if (slot_ptr > last_tx_slot) cur_phase = PH_BREAK;
              end
              PH_BREAK: begin
                r.tx_valid = 1'b1;
                r.tx_kind  = KIND_BREAK;
                slot_ptr   = '0;
                cur_phase  = PH_START;
              end
              PH_START: begin
                r.tx_valid = 1'b1;
                r.tx_kind  = KIND_START;
                r.tx_byte  = slot_rd(slot_ptr);
                slot_ptr   = slot_ptr + 1'b1;
                cur_phase  = PH_DATA;
              end
              default: ;
            endcase
          end
        end
        CMD_WR: slot_wr(idx, val);
        default: r.read_value = slot_rd(idx);
      endcase
      replies_due.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_reply(logic [31:0] tdata, logic [1:0] tuser);
      reply_t e;
      if (replies_due.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %h", tdata, tuser);
        fails++;
        return;
      end
      e = replies_due.pop_front();
      cmp_field("tx_valid", e.tx_valid, tdata[0]);
      cmp_field("tx_kind", e.tx_kind, tuser);
      cmp_field("tx_byte", e.tx_byte, tdata[8:1]);
      cmp_field("frame_done", e.frame_done, tdata[9]);
      cmp_field("frame_slots", e.frame_slots, tdata[19:10]);
      cmp_field("read_value", e.read_value, tdata[27:20]);
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [0:0]        cfg_idx_i     = '0;
  logic [SLOT_W-1:0] cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;
  logic [2:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  dmx_slot_tracker tracker = new();
  int unsigned     items_sent;
  int unsigned     burst_left;
  int unsigned     stall_cycles;
  bit              hold_wanted;

  dmx512_slot_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- sender

  function automatic bit [SLOT_W-1:0] pick_slot();
    // mostly valid addresses, now and then anything the field can hold
    if ($urandom_range(0, 9) == 0) return SLOT_W'($urandom_range(0, 1023));
    return SLOT_W'($urandom_range(0, LAST_SLOT));
  endfunction

  task automatic push_event(cmd_e cmd, bit [7:0] rx, bit ferr, bit [SLOT_W-1:0] idx,
                            bit [7:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 :
                   ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) :
                   $urandom_range(1, 12);
      burst_left = $urandom_range(1, 50);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, idx, rx};
    s_axis_tuser  <= {ferr, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.play_event(cmd, rx, ferr, idx, val);
    items_sent++;
    burst_left--;
  endtask

  task automatic push_rx(bit [7:0] rx, bit ferr);
    push_event(CMD_RX, rx, ferr, SLOT_W'($urandom_range(0, 1023)), 8'($urandom));
  endtask

  task automatic push_host(cmd_e cmd, bit [SLOT_W-1:0] idx, bit [7:0] val);
    push_event(cmd, 8'($urandom), 1'($urandom), idx, val);
  endtask

  task automatic push_txrdy();
    push_event(CMD_TX_RDY, 8'($urandom), 1'($urandom), SLOT_W'($urandom_range(0, 1023)),
               8'($urandom));
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [SLOT_W-1:0] data);
    drain_replies();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_output_phase(int unsigned count);
    int unsigned end_mark;
    end_mark = items_sent + count;
    while (items_sent < end_mark) begin
      case ($urandom_range(0, 19))
        0:       push_host(CMD_WR, pick_slot(), 8'($urandom));
        1:       push_host(CMD_RD, pick_slot(), 8'($urandom));
        2:       push_rx(8'($urandom), 1'($urandom));
        default: push_txrdy();
      endcase
      if ($urandom_range(0, 299) == 0) drain_replies();
    end
  endtask

  // well-formed frames with random content, plus stray breaks and host traffic
  task automatic run_input_phase(int unsigned count, bit long_frame);
    int unsigned end_mark;
    int unsigned n_data;
    bit [7:0]    start_code;
    end_mark = items_sent + count;
    while (items_sent < end_mark) begin
      if ($urandom_range(0, 9) != 0) push_rx(8'($urandom), 1'b1);
      if ($urandom_range(0, 9) == 0) push_rx(8'($urandom), 1'b1);
      start_code = ($urandom_range(0, 4) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
      push_rx(start_code, 1'b0);
      n_data = long_frame ? 520 : $urandom_range(0, 30);
      repeat (n_data) begin
        if (long_frame) push_rx(8'($urandom), 1'b0);
        else begin
          case ($urandom_range(0, 39))
            0:       push_rx(8'($urandom), 1'b1);
            1:       push_host(CMD_WR, pick_slot(), 8'($urandom));
            2:       push_host(CMD_RD, pick_slot(), 8'($urandom));
            3:       push_txrdy();
            default: push_rx(8'($urandom), 1'b0);
          endcase
        end
      end
      long_frame = 1'b0;
      if ($urandom_range(0, 19) == 0) drain_replies();
    end
    push_rx(8'($urandom), 1'b1);
  endtask

  task automatic run_noise_phase(int unsigned count);
    repeat (count) begin
      push_event(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), pick_slot(),
                 8'($urandom));
    end
  endtask

  initial begin : stimulus
    bit [1:0]          mode_v;
    logic [SLOT_W-1:0] max_v;
    int unsigned       pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // off mode after reset: host access to the slot memory and its edges
    push_host(CMD_RD, 10'd0, 8'h00);
    push_host(CMD_WR, 10'd0, 8'hFF);
    push_host(CMD_WR, 10'd512, 8'hA5);
    push_host(CMD_WR, 10'd513, 8'h5A);
    push_host(CMD_WR, 10'd1023, 8'h00);
    push_host(CMD_RD, 10'd512, 8'h00);
    push_host(CMD_RD, 10'd513, 8'hFF);
    push_host(CMD_RD, 10'd1023, 8'hFF);
    push_rx(8'hFF, 1'b1);
    push_txrdy();

    // mode 3 acts as off
    set_reg(CFG_MODE, 10'h3FF);
    push_txrdy();
    push_rx(8'h00, 1'b0);

    // output with the frame length clamped up to the minimum
    set_reg(CFG_MAX, 10'd0);
    set_reg(CFG_MODE, {8'h00, MODE_OUT});
    repeat (3) push_txrdy();

    // input: idle until a break, empty break, short frame, rejected start code
    set_reg(CFG_MODE, {8'h00, MODE_IN});
    push_rx(8'h00, 1'b0);
    push_rx(8'h00, 1'b1);
    push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'h80, 1'b1);
    push_rx(8'h17, 1'b0);
    push_rx(8'h33, 1'b0);
    push_rx(8'hFF, 1'b1);
    push_txrdy();
    push_host(CMD_RD, 10'd1, 8'h00);

    for (int ph = 0; items_sent < ITEMS_TARGET; ph++) begin
      pick = $urandom_range(0, 9);
      mode_v = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : (pick < 6) ? MODE_OUT : MODE_IN;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: max_v = SLOT_W'($urandom_range(0, 60));
        5:             max_v = 10'd23;
        6:             max_v = 10'd512;
        7:             max_v = 10'd513;
        default:       max_v = SLOT_W'($urandom_range(0, 1023));
      endcase
      if (ph == 0) begin
        mode_v = MODE_OUT;
        max_v  = 10'd1023;
      end else if (ph == 1) begin
        mode_v = MODE_IN;
        max_v  = 10'd0;
      end
      if (ph < 2 || $urandom_range(0, 3) != 0) set_reg(CFG_MAX, max_v);
      set_reg(CFG_MODE, {8'($urandom), mode_v});
      // the receiver holds off during the first long output frame
      if (ph == 0) hold_wanted = 1'b1;
      if (mode_v == MODE_OUT) run_output_phase((ph == 0) ? 600 : $urandom_range(40, 200));
      else if (mode_v == MODE_IN) run_input_phase((ph == 1) ? 530 : $urandom_range(40, 200),
                                                  ph == 1);
      else run_noise_phase($urandom_range(20, 60));
    end

    drain_replies();
    repeat (16) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("dmx512_slot_engine_unit regression: pass");
    end else begin
      $display("dmx512_slot_engine_unit regression: fail");
    end
    $finish;
  end

  // -------------------------------------------------------------- receiver

  initial begin : result_sink
    int unsigned style;
    int unsigned len;
    forever begin
      style = $urandom_range(0, 4);
      len   = $urandom_range(4, 80);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        style       = 5;
        len         = LONG_HOLD;
      end
      for (int i = 0; i < len; i++) begin
        @(posedge clk_i);
        case (style)
          0, 1:    m_axis_tready <= 1'b1;
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          3:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          4:       m_axis_tready <= (i % 3 == 2);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_reply(m_axis_tdata, m_axis_tuser);
    end
  end

  // no transaction on either side for too long means the block is hung
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("dmx512_slot_engine_unit regression: fail");
        $finish;
      end
    end
  end

endmodule
